/* src/fpbc_pkg.sv */
package fpbc_pkg;

    localparam int COORD_BITS = 16;
    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * COORD_BITS + 2;
    localparam int NORMAL_W   = 2 * COORD_BITS + 3;
    localparam int TERM_W     = NORMAL_W + COORD_BITS;
    localparam int OFFSET_W   = 3 * COORD_BITS + 4;
    localparam int EVAL_W     = 3 * COORD_BITS + 6;

    localparam int S_RAW_W    = 9 * COORD_BITS;
    localparam int S_DATA_W   = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W    = 3 * NORMAL_W + OFFSET_W;
    localparam int M_DATA_W   = ((M_RAW_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERIOR_X = 3'd0,
        REG_INTERIOR_Y = 3'd1,
        REG_INTERIOR_Z = 3'd2,
        REG_CAMERA_X   = 3'd3,
        REG_CAMERA_Y   = 3'd4,
        REG_CAMERA_Z   = 3'd5,
        REG_PROJ_MODE  = 3'd6
    } cfg_index_e;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]     edge_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [NORMAL_W-1:0]   normal_coef_t;
    typedef logic signed [TERM_W-1:0]     term_t;
    typedef logic signed [OFFSET_W-1:0]   offset_t;
    typedef logic signed [EVAL_W-1:0]     eval_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        edge_t x;
        edge_t y;
        edge_t z;
    } edge_vec_t;

    typedef struct packed {
        normal_coef_t a;
        normal_coef_t b;
        normal_coef_t c;
    } normal_t;

    typedef struct packed {
        normal_coef_t a;
        normal_coef_t b;
        normal_coef_t c;
        offset_t      d;
    } plane_t;

    typedef struct packed {
        logic   flip;
        logic   visible;
        plane_t plane;
    } plane_test_t;

    typedef struct packed {
        vec_t interior;
        vec_t camera;
        logic parallel;
    } cfg_t;

endpackage

/* src/fpbc_edge_cross.sv */
module fpbc_edge_cross import fpbc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  vec_t    v0,
    input  vec_t    v1,
    input  vec_t    v2,
    output logic    out_valid,
    output normal_t normal,
    output vec_t    out_v0
);

    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    edge_vec_t e1_reg, e2_reg;
    vec_t      s1_v0_reg, s2_v0_reg, s3_v0_reg;
    prod_t     p_reg [6];
    normal_t   normal_reg;

    edge_vec_t e1_next, e2_next;
    prod_t     p_next [6];
    normal_t   normal_next;

    assign e1_next.x = edge_t'(v1.x) - edge_t'(v0.x);
    assign e1_next.y = edge_t'(v1.y) - edge_t'(v0.y);
    assign e1_next.z = edge_t'(v1.z) - edge_t'(v0.z);
    assign e2_next.x = edge_t'(v2.x) - edge_t'(v0.x);
    assign e2_next.y = edge_t'(v2.y) - edge_t'(v0.y);
    assign e2_next.z = edge_t'(v2.z) - edge_t'(v0.z);

    assign p_next[0] = e2_reg.y * e1_reg.z;
    assign p_next[1] = e1_reg.y * e2_reg.z;
    assign p_next[2] = e1_reg.x * e2_reg.z;
    assign p_next[3] = e2_reg.x * e1_reg.z;
    assign p_next[4] = e2_reg.x * e1_reg.y;
    assign p_next[5] = e1_reg.x * e2_reg.y;

    assign normal_next.a = normal_coef_t'(p_reg[0]) - normal_coef_t'(p_reg[1]);
    assign normal_next.b = normal_coef_t'(p_reg[2]) - normal_coef_t'(p_reg[3]);
    assign normal_next.c = normal_coef_t'(p_reg[4]) - normal_coef_t'(p_reg[5]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg     <= e1_next;
            e2_reg     <= e2_next;
            s1_v0_reg  <= v0;
            p_reg      <= p_next;
            s2_v0_reg  <= s1_v0_reg;
            normal_reg <= normal_next;
            s3_v0_reg  <= s2_v0_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign normal    = normal_reg;
    assign out_v0    = s3_v0_reg;

endmodule

/* src/fpbc_plane_eval.sv */
module fpbc_plane_eval import fpbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  normal_t     normal,
    input  vec_t        v0,
    output logic        out_valid,
    output plane_test_t result
);

    logic        s4_valid_reg, s5_valid_reg, s6_valid_reg;
    term_t       t_reg [9];
    normal_t     s4_normal_reg, s5_normal_reg;
    offset_t     d_reg;
    eval_t       sum_in_reg, sum_view_reg;
    plane_test_t result_reg;

    term_t       t_next [9];
    eval_t       sum_v0, sum_in_next, sum_view_next;
    offset_t     d_next;
    eval_t       d_ext, interior_val, view;
    logic        flip, view_neg, view_pos;
    plane_test_t result_next;

    assign t_next[0] = normal.a * v0.x;
    assign t_next[1] = normal.b * v0.y;
    assign t_next[2] = normal.c * v0.z;
    assign t_next[3] = normal.a * cfg.interior.x;
    assign t_next[4] = normal.b * cfg.interior.y;
    assign t_next[5] = normal.c * cfg.interior.z;
    assign t_next[6] = normal.a * cfg.camera.x;
    assign t_next[7] = normal.b * cfg.camera.y;
    assign t_next[8] = normal.c * cfg.camera.z;

    assign sum_v0        = eval_t'(t_reg[0]) + eval_t'(t_reg[1]) + eval_t'(t_reg[2]);
    assign d_next        = offset_t'(-sum_v0);
    assign sum_in_next   = eval_t'(t_reg[3]) + eval_t'(t_reg[4]) + eval_t'(t_reg[5]);
    assign sum_view_next = eval_t'(t_reg[6]) + eval_t'(t_reg[7]) + eval_t'(t_reg[8]);

    // The view sign is taken from the unoriented plane and mirrored when the plane flips.
    assign d_ext        = eval_t'(d_reg);
    assign interior_val = sum_in_reg + d_ext;
    assign view         = cfg.parallel ? sum_view_reg : sum_view_reg + d_ext;
    assign flip         = interior_val[EVAL_W-1];
    assign view_neg     = view[EVAL_W-1];
    assign view_pos     = !view[EVAL_W-1] && (view != '0);

    always_comb begin
        result_next.flip    = flip;
        result_next.visible = flip ? view_pos : view_neg;
        result_next.plane.a = s5_normal_reg.a;
        result_next.plane.b = s5_normal_reg.b;
        result_next.plane.c = s5_normal_reg.c;
        result_next.plane.d = d_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg         <= t_next;
            s4_normal_reg <= normal;
            d_reg         <= d_next;
            sum_in_reg    <= sum_in_next;
            sum_view_reg  <= sum_view_next;
            s5_normal_reg <= s4_normal_reg;
            result_reg    <= result_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign result    = result_reg;

endmodule

/* src/fpbc_orient.sv */
module fpbc_orient import fpbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  plane_test_t in_result,
    output logic        out_valid,
    output plane_t      plane,
    output logic        visible
);

    logic   valid_reg;
    plane_t plane_reg;
    logic   visible_reg;
    plane_t plane_next;

    always_comb begin
        if (in_result.flip) begin
            plane_next.a = -in_result.plane.a;
            plane_next.b = -in_result.plane.b;
            plane_next.c = -in_result.plane.c;
            plane_next.d = -in_result.plane.d;
        end else begin
            plane_next = in_result.plane;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plane_reg   <= plane_next;
            visible_reg <= in_result.visible;
        end
    end

    assign out_valid = valid_reg;
    assign plane     = plane_reg;
    assign visible   = visible_reg;

endmodule

/* src/face_plane_backface_cull_core.sv */
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: one triangle, three vertices
// m_        out        m_tvalid / m_tready    m_tdata: oriented plane, m_tuser: visible
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data: one register write
//
// One triangle is accepted per cycle unless the output stalls; results leave in order.
// The depth is set by the two multiplier ranks, the sums and the final orientation negate.
// Reset clears all valid flags and the configuration registers.
// A stall on the output freezes every stage at once; s_tready follows the output register.
// Configuration writes are always accepted.
module face_plane_backface_cull_core import fpbc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // plane_a, plane_b, plane_c, plane_d, zero padding
    output logic [M_DATA_W-1:0]  m_tdata,
    // visible
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        en;
    vec_t        v0, v1, v2;
    logic        cross_valid, eval_valid;
    normal_t     normal;
    vec_t        cross_v0;
    plane_test_t eval_result;
    plane_t      plane;
    logic        visible;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_INTERIOR_X: cfg_reg.interior.x <= coord_t'(cfg_data);
                REG_INTERIOR_Y: cfg_reg.interior.y <= coord_t'(cfg_data);
                REG_INTERIOR_Z: cfg_reg.interior.z <= coord_t'(cfg_data);
                REG_CAMERA_X:   cfg_reg.camera.x   <= coord_t'(cfg_data);
                REG_CAMERA_Y:   cfg_reg.camera.y   <= coord_t'(cfg_data);
                REG_CAMERA_Z:   cfg_reg.camera.z   <= coord_t'(cfg_data);
                REG_PROJ_MODE:  cfg_reg.parallel   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign v0.x = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign v0.y = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign v0.z = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign v1.x = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign v1.y = s_tdata[4*COORD_BITS +: COORD_BITS];
    assign v1.z = s_tdata[5*COORD_BITS +: COORD_BITS];
    assign v2.x = s_tdata[6*COORD_BITS +: COORD_BITS];
    assign v2.y = s_tdata[7*COORD_BITS +: COORD_BITS];
    assign v2.z = s_tdata[8*COORD_BITS +: COORD_BITS];

    fpbc_edge_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .v0        (v0),
        .v1        (v1),
        .v2        (v2),
        .out_valid (cross_valid),
        .normal    (normal),
        .out_v0    (cross_v0)
    );

    fpbc_plane_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (cross_valid),
        .normal    (normal),
        .v0        (cross_v0),
        .out_valid (eval_valid),
        .result    (eval_result)
    );

    fpbc_orient u_orient (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (eval_valid),
        .in_result (eval_result),
        .out_valid (m_tvalid),
        .plane     (plane),
        .visible   (visible)
    );

    assign m_tdata = M_DATA_W'({plane.d, plane.c, plane.b, plane.a});
    assign m_tuser = visible;

endmodule

/* src/fpbc_checker.sv */
module fpbc_checker import fpbc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    logic normal_zero;
    logic offset_zero;

    assign normal_zero = (m_tdata[3*NORMAL_W-1:0] == '0);
    assign offset_zero = (m_tdata[M_RAW_W-1:3*NORMAL_W] == '0);

    // A result held back by the sink keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transfer changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // With no result waiting, the input side must be open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A degenerate triangle has a zero plane and can never be visible.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && normal_zero |-> offset_zero && !m_tuser)
        else $error("zero normal with non-zero offset or visible flag");

endmodule

bind face_plane_backface_cull_core fpbc_checker u_fpbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
